// File: sv/msmt_pkg.sv
// ----------------------------------------------------------------------------
// msmt_pkg: shared types and constants of the mode-sum tracker
// Item layouts, table word layout and default sizes.
// ----------------------------------------------------------------------------
package msmt_pkg;

	localparam int NUM_VALUES_DEF = 1024;
	localparam int MAX_COUNT_DEF  = 1023;

	localparam int VALUE_W = 10;
	localparam int TOP_W   = 10;
	localparam int SUM_W   = 20;
	localparam int VAC_W   = 11;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] dominant_sum;
		logic [TOP_W-1:0] top_count;
		logic             rejected;
	} rsp_item_t;

	// one entry per count level: values at exactly that count, sum at that level
	typedef struct packed {
		logic [VAC_W-1:0] vac;
		logic [SUM_W-1:0] sum;
	} level_word_t;

endpackage

// File: sv/msmt_count_mem.sv
// ----------------------------------------------------------------------------
// msmt_count_mem: per-value count memory
// Single read port, single write port, registered read data.
// ----------------------------------------------------------------------------
module msmt_count_mem #(
	parameter int AW = 10,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/msmt_level_mem.sv
// ----------------------------------------------------------------------------
// msmt_level_mem: per-level table memory
// Holds values-at-count and sum-at-level words; two read ports, one write.
// ----------------------------------------------------------------------------
module msmt_level_mem #(
	parameter int AW = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr_a,
	input  logic [AW-1:0]        rd_addr_b,
	output msmt_pkg::level_word_t rd_data_a,
	output msmt_pkg::level_word_t rd_data_b,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  msmt_pkg::level_word_t wr_data
);

	msmt_pkg::level_word_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: sv/multiset_mode_sum_tracker_unit.sv
// ----------------------------------------------------------------------------
// multiset_mode_sum_tracker_unit: multiset mode-sum tracker
// Result: registered after states RD, LV and WN, once the output slot frees.
// Items: no new item until the last is through the count read, the level
//   table read and the two level table writes; hold while a result waits.
// Reset: clears control at once, then sweeps max(NUM_VALUES, MAX_COUNT+1)
//   entries (rounded up to a power of two) to zero, one per cycle, idle.
// ----------------------------------------------------------------------------
module multiset_mode_sum_tracker_unit #(
	parameter int NUM_VALUES = msmt_pkg::NUM_VALUES_DEF,
	parameter int MAX_COUNT  = msmt_pkg::MAX_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  msmt_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output msmt_pkg::rsp_item_t rsp_item
);

	localparam int VC_AW = $clog2(NUM_VALUES);
	localparam int CW    = $clog2(MAX_COUNT + 1);
	localparam int CLR_W = (VC_AW > CW) ? VC_AW : CW;

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RD   = 5'b00100,
		ST_LV   = 5'b01000,
		ST_WN   = 5'b10000
	} state_t;

	state_t state_q;
	logic [CLR_W-1:0] clr_q;

	logic                         mode_q;
	logic [msmt_pkg::VALUE_W-1:0] value_q;
	logic                         ok_q;
	logic [CW-1:0]                c_q;
	logic [CW-1:0]                n_q;
	logic [CW-1:0]                top_q;
	logic [msmt_pkg::SUM_W-1:0]   top_sum_q;

	logic                rsp_valid_q;
	msmt_pkg::rsp_item_t rsp_item_q;

	logic          vc_rd_en;
	logic [CW-1:0] vc_rd_data;
	logic          vc_wr_en;
	logic [VC_AW-1:0] vc_wr_addr;
	logic [CW-1:0] vc_wr_data;

	msmt_pkg::level_word_t lv_rd_a;
	msmt_pkg::level_word_t lv_rd_b;
	logic                  lv_wr_en;
	logic [CW-1:0]         lv_wr_addr;
	msmt_pkg::level_word_t lv_wr_data;

	logic          accept;
	logic          slot_free;
	logic          in_range;
	logic          ok_now;
	logic [CW-1:0] n_now;

	msmt_pkg::level_word_t      word_c;
	msmt_pkg::level_word_t      word_n;
	logic [CW-1:0]              top_new;
	logic [msmt_pkg::SUM_W-1:0] sum_new;
	logic [msmt_pkg::SUM_W-1:0] v_ext;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// count lookup
	assign vc_rd_en = accept;
	assign in_range = (int'(value_q) < NUM_VALUES);

	always_comb begin
		if (mode_q == msmt_pkg::MODE_INSERT) begin
			ok_now = in_range && (vc_rd_data < CW'(MAX_COUNT));
			n_now  = vc_rd_data + CW'(1);
		end else begin
			ok_now = in_range && (vc_rd_data != '0);
			n_now  = vc_rd_data - CW'(1);
		end
	end

	// level update
	assign v_ext = msmt_pkg::SUM_W'(value_q);

	always_comb begin
		word_c.vac = lv_rd_a.vac - msmt_pkg::VAC_W'(1);
		word_c.sum = lv_rd_a.sum;
		word_n.vac = lv_rd_b.vac + msmt_pkg::VAC_W'(1);
		word_n.sum = lv_rd_b.sum;
		top_new    = top_q;
		sum_new    = top_sum_q;
		if (mode_q == msmt_pkg::MODE_INSERT) begin
			word_n.sum = lv_rd_b.sum + v_ext;
			if (n_q >= top_q) begin
				top_new = n_q;
				sum_new = lv_rd_b.sum + v_ext;
			end
		end else begin
			word_c.sum = lv_rd_a.sum - v_ext;
			if (c_q == top_q) begin
				if (lv_rd_a.vac == msmt_pkg::VAC_W'(1)) begin
					top_new = n_q;
					sum_new = (n_q == '0) ? '0 : lv_rd_b.sum;
				end else begin
					sum_new = lv_rd_a.sum - v_ext;
				end
			end
		end
	end

	// memory write selection
	always_comb begin
		vc_wr_en   = 1'b0;
		vc_wr_addr = VC_AW'(value_q);
		vc_wr_data = n_now;
		lv_wr_en   = 1'b0;
		lv_wr_addr = c_q;
		lv_wr_data = word_c;
		unique case (state_q)
			ST_CLR: begin
				vc_wr_en   = 1'b1;
				vc_wr_addr = clr_q[VC_AW-1:0];
				vc_wr_data = '0;
				lv_wr_en   = 1'b1;
				lv_wr_addr = clr_q[CW-1:0];
				lv_wr_data = '0;
			end
			ST_RD: begin
				vc_wr_en = ok_now;
			end
			ST_LV: begin
				lv_wr_en = ok_q && (c_q != '0);
			end
			ST_WN: begin
				lv_wr_en   = ok_q && (n_q != '0);
				lv_wr_addr = n_q;
				lv_wr_data = word_n;
			end
			default: begin
			end
		endcase
	end

	msmt_count_mem #(
		.AW(VC_AW),
		.DW(CW)
	) u_count_mem (
		.clk     (clk),
		.rd_en   (vc_rd_en),
		.rd_addr (VC_AW'(req_item.value)),
		.rd_data (vc_rd_data),
		.wr_en   (vc_wr_en),
		.wr_addr (vc_wr_addr),
		.wr_data (vc_wr_data)
	);

	msmt_level_mem #(
		.AW(CW)
	) u_level_mem (
		.clk       (clk),
		.rd_en     (state_q == ST_RD),
		.rd_addr_a (vc_rd_data),
		.rd_addr_b (n_now),
		.rd_data_a (lv_rd_a),
		.rd_data_b (lv_rd_b),
		.wr_en     (lv_wr_en),
		.wr_addr   (lv_wr_addr),
		.wr_data   (lv_wr_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			top_q     <= '0;
			top_sum_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LV;
				end
				ST_LV: begin
					if (ok_q) begin
						top_q     <= top_new;
						top_sum_q <= sum_new;
					end
					state_q <= ST_WN;
				end
				ST_WN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req_item.mode;
			value_q <= req_item.value;
		end
		if (state_q == ST_RD) begin
			ok_q <= ok_now;
			c_q  <= vc_rd_data;
			n_q  <= n_now;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_WN) && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WN) && slot_free) begin
			rsp_item_q.dominant_sum <= (top_q == '0) ? '0 : top_sum_q;
			rsp_item_q.top_count    <= msmt_pkg::TOP_W'(top_q);
			rsp_item_q.rejected     <= !ok_q;
		end
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multiset mode-sum tracker
// Drives insert and remove items against a local model of the count tables.
// The model predicts the dominant sum, the top count and the reject flag of
// every item. A directed table covers removal of absent values, ties,
// climbing one value forty-one levels, and draining it again. Random items
// follow, mostly from small value pools so that counts climb and ties form.
// Both sides idle at random. The receiver holds off once for a long stretch,
// and the sender drains the block once before going on.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV             = msmt_pkg::NUM_VALUES_DEF;
	localparam int MC             = msmt_pkg::MAX_COUNT_DEF;
	localparam int N_RAND         = 854;
	localparam int N_DIR_ROWS     = 18;
	localparam int HOLD_AT        = 300;
	localparam int DRAIN_AT       = 600;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic                         mode;
		logic [msmt_pkg::VALUE_W-1:0] value;
		logic [10:0]                  reps;
		logic                         fix;
		logic [msmt_pkg::SUM_W-1:0]   sum;
		logic [msmt_pkg::TOP_W-1:0]   top;
		logic                         rej;
	} dir_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	msmt_pkg::req_item_t req_item  = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	msmt_pkg::rsp_item_t rsp_item;

	logic                cur_fixed     = 1'b0;
	msmt_pkg::rsp_item_t cur_fixed_rsp = '0;

	logic [msmt_pkg::TOP_W-1:0] cnt_tab [NV];
	logic [msmt_pkg::VAC_W-1:0] vac_tab [MC+1];
	logic [msmt_pkg::SUM_W-1:0] lvl_sum [MC+1];
	logic [msmt_pkg::TOP_W-1:0] top_lvl;

	msmt_pkg::rsp_item_t expected_mode_sums [$];
	dir_row_t            dir_tab [N_DIR_ROWS];

	int  errors       = 0;
	int  n_items      = 0;
	int  n_results    = 0;
	int  n_rejected   = 0;
	int  n_directed   = 0;
	int  max_top_seen = 0;
	int  idle_cnt     = 0;
	bit  burst        = 0;
	bit  rsp_burst    = 0;
	bit  hold_req     = 0;
	bit  hold_taken   = 0;

	multiset_mode_sum_tracker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #4 clk = ~clk;

	function automatic msmt_pkg::rsp_item_t mode_sum_step(msmt_pkg::req_item_t it);
		msmt_pkg::rsp_item_t r;
		int                  v;
		int                  c;
		bit                  ok;
		v  = it.value;
		c  = cnt_tab[v];
		ok = 1'b0;
		if (v < NV) begin
			if (it.mode == msmt_pkg::MODE_INSERT) begin
				if (c < MC) begin
					ok         = 1'b1;
					cnt_tab[v] = msmt_pkg::TOP_W'(c + 1);
					if (c > 0)
						vac_tab[c] = vac_tab[c] - 1'b1;
					vac_tab[c+1] = vac_tab[c+1] + 1'b1;
					if (c + 1 > top_lvl)
						top_lvl = msmt_pkg::TOP_W'(c + 1);
					lvl_sum[c+1] = lvl_sum[c+1] + msmt_pkg::SUM_W'(v);
				end
			end else if (c > 0) begin
				ok         = 1'b1;
				cnt_tab[v] = msmt_pkg::TOP_W'(c - 1);
				vac_tab[c] = vac_tab[c] - 1'b1;
				if (c > 1)
					vac_tab[c-1] = vac_tab[c-1] + 1'b1;
				if (top_lvl > 0 && vac_tab[top_lvl] == '0)
					top_lvl = top_lvl - 1'b1;
				lvl_sum[c] = lvl_sum[c] - msmt_pkg::SUM_W'(v);
			end
		end
		r.dominant_sum = (top_lvl > 0) ? lvl_sum[top_lvl] : '0;
		r.top_count    = top_lvl;
		r.rejected     = !ok;
		return r;
	endfunction

	always @(posedge clk) begin : track
		msmt_pkg::rsp_item_t p;
		msmt_pkg::rsp_item_t e;
		if (arst_n) begin
			if (req_valid && req_stall === 1'b0) begin
				p = mode_sum_step(req_item);
				n_items++;
				if (p.top_count > max_top_seen)
					max_top_seen = p.top_count;
				expected_mode_sums = {expected_mode_sums, (cur_fixed ? cur_fixed_rsp : p)};
			end
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				n_results++;
				if (expected_mode_sums.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $realtime, rsp_item);
					errors++;
				end else begin
					e = expected_mode_sums.pop_front();
					if (rsp_item.dominant_sum !== e.dominant_sum) begin
						$display("%0t: dominant_sum expected %0d actual %0d",
							$realtime, e.dominant_sum, rsp_item.dominant_sum);
						errors++;
					end
					if (rsp_item.top_count !== e.top_count) begin
						$display("%0t: top_count expected %0d actual %0d",
							$realtime, e.top_count, rsp_item.top_count);
						errors++;
					end
					if (rsp_item.rejected !== e.rejected) begin
						$display("%0t: rejected expected %0b actual %0b",
							$realtime, e.rejected, rsp_item.rejected);
						errors++;
					end
					if (rsp_item.rejected === 1'b1)
						n_rejected++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, idle_cnt);
			$display("multiset_mode_sum_tracker_unit verification failed");
			$finish;
		end
	end

	task automatic send_item(input msmt_pkg::req_item_t it, input logic fix,
		input msmt_pkg::rsp_item_t fx);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		req_item      <= it;
		cur_fixed     <= fix;
		cur_fixed_rsp <= fx;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic drain_block();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_mode_sums.size() != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int n;
		int k;
		k = 0;
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				n          = HOLD_CYCLES;
			end else begin
				n = rsp_burst ? 0 : $urandom_range(0, 8);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			k++;
			if (k % 40 == 0)
				rsp_burst = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : stimulus
		msmt_pkg::req_item_t          it;
		msmt_pkg::rsp_item_t          fx;
		logic [msmt_pkg::VALUE_W-1:0] pool [12];
		int                           pool_n;
		for (int i = 0; i < NV; i++)
			cnt_tab[i] = '0;
		for (int i = 0; i <= MC; i++) begin
			vac_tab[i] = '0;
			lvl_sum[i] = '0;
		end
		top_lvl = '0;

		dir_tab = '{
			'{msmt_pkg::MODE_REMOVE,    5,  1, 1'b1,    0,  0, 1'b1},
			'{msmt_pkg::MODE_INSERT, 1023,  1, 1'b1, 1023,  1, 1'b0},
			'{msmt_pkg::MODE_INSERT,    0,  1, 1'b1, 1023,  1, 1'b0},
			'{msmt_pkg::MODE_INSERT,    0,  1, 1'b1,    0,  2, 1'b0},
			'{msmt_pkg::MODE_REMOVE,    0,  1, 1'b1, 1023,  1, 1'b0},
			'{msmt_pkg::MODE_REMOVE,    0,  1, 1'b1, 1023,  1, 1'b0},
			'{msmt_pkg::MODE_REMOVE,    0,  1, 1'b1, 1023,  1, 1'b1},
			'{msmt_pkg::MODE_REMOVE, 1023,  1, 1'b1,    0,  0, 1'b0},
			'{msmt_pkg::MODE_INSERT, 1023, 40, 1'b0,    0,  0, 1'b0},
			'{msmt_pkg::MODE_INSERT, 1023,  1, 1'b1, 1023, 41, 1'b0},
			'{msmt_pkg::MODE_REMOVE, 1023, 40, 1'b0,    0,  0, 1'b0},
			'{msmt_pkg::MODE_REMOVE, 1023,  1, 1'b1,    0,  0, 1'b0},
			'{msmt_pkg::MODE_INSERT,  341,  1, 1'b0,    0,  0, 1'b0},
			'{msmt_pkg::MODE_INSERT,  682,  1, 1'b0,    0,  0, 1'b0},
			'{msmt_pkg::MODE_INSERT,  341,  1, 1'b1,  341,  2, 1'b0},
			'{msmt_pkg::MODE_REMOVE,  682,  1, 1'b1,  341,  2, 1'b0},
			'{msmt_pkg::MODE_REMOVE,  341,  1, 1'b1,  341,  1, 1'b0},
			'{msmt_pkg::MODE_REMOVE,  341,  1, 1'b1,    0,  0, 1'b0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIR_ROWS; r++) begin
			it.mode         = dir_tab[r].mode;
			it.value        = dir_tab[r].value;
			fx.dominant_sum = dir_tab[r].sum;
			fx.top_count    = dir_tab[r].top;
			fx.rejected     = dir_tab[r].rej;
			for (int k = 0; k < dir_tab[r].reps; k++) begin
				send_item(it, dir_tab[r].fix, fx);
				n_directed++;
			end
		end

		fx     = '0;
		pool_n = 1;
		for (int k = 0; k < N_RAND; k++) begin
			if (k % 64 == 0) begin
				pool_n = $urandom_range(2, 12);
				for (int i = 0; i < 12; i++)
					pool[i] = msmt_pkg::VALUE_W'($urandom_range(0, NV - 1));
				burst = ($urandom_range(0, 3) == 0);
			end
			if (k == HOLD_AT)
				hold_req = 1;
			if (k == DRAIN_AT)
				drain_block();
			it.mode = ($urandom_range(0, 99) < 55) ? msmt_pkg::MODE_INSERT
				: msmt_pkg::MODE_REMOVE;
			if ($urandom_range(0, 99) < 85)
				it.value = pool[$urandom_range(0, pool_n - 1)];
			else
				it.value = msmt_pkg::VALUE_W'($urandom_range(0, NV - 1));
			send_item(it, 1'b0, fx);
		end

		drain_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_mode_sums.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, expected_mode_sums.size());
			errors++;
		end

		$display("Ran %0d items (%0d directed, %0d random) and checked %0d results.",
			n_items, n_directed, N_RAND, n_results);
		$display("Saw %0d refused items, top count up to %0d, %0d mismatches.",
			n_rejected, max_top_seen, errors);
		if (errors == 0)
			$display("multiset_mode_sum_tracker_unit verification clean");
		else
			$display("multiset_mode_sum_tracker_unit verification failed");
		$finish;
	end

endmodule
